@@ rtl/s2c_pkg.sv @@
// ----------------------------------------------------------------------------
// s2c_pkg: shared types, constants and functions for spherical_to_cartesian
// Fixed-point formats, CORDIC arctangent table and per-stage datapath steps.
// ----------------------------------------------------------------------------
`default_nettype none

package s2c_pkg;

   localparam int CORDIC_STAGES = 24;
   localparam int CORDIC_N      = (CORDIC_STAGES > 30) ? 30 : CORDIC_STAGES;

   localparam int ANG_W   = 32;   // Q4.28 angle input
   localparam int DIST_W  = 26;   // unsigned distance
   localparam int COORD_W = 27;   // signed coordinate
   localparam int WRAP_W  = 36;   // Q.30 angle before folding
   localparam int FRAC_W  = 32;   // Q2.30 sine / cosine
   localparam int PROD_W  = 2 * FRAC_W;
   localparam int SCALE_W = DIST_W + 1 + FRAC_W;
   localparam int SHIFT_W = SCALE_W - 30;

   localparam logic signed [WRAP_W-1:0] ANG_PI      = 36'sd3373259426;
   localparam logic signed [WRAP_W-1:0] ANG_HALF_PI = 36'sd1686629713;
   localparam logic signed [WRAP_W-1:0] ANG_TWO_PI  = 36'sd6746518852;
   localparam logic signed [FRAC_W-1:0] INV_GAIN    = 32'sd652032874;

   localparam logic signed [SHIFT_W-1:0] OUT_MAX = 29'sd67108863;
   localparam logic signed [SHIFT_W-1:0] OUT_MIN = -29'sd67108864;

   typedef struct packed {
      logic signed [FRAC_W-1:0] x;
      logic signed [FRAC_W-1:0] y;
      logic signed [FRAC_W-1:0] z;
   } rot_type;

   typedef struct packed {
      logic                     neg;
      logic signed [FRAC_W-1:0] z;
   } fold_type;

   function automatic logic signed [FRAC_W-1:0] atan_val(input int idx);
      logic signed [FRAC_W-1:0] v;
      case (idx)
         0:  v = 32'sd843314856;
         1:  v = 32'sd497837829;
         2:  v = 32'sd263043836;
         3:  v = 32'sd133525158;
         4:  v = 32'sd67021686;
         5:  v = 32'sd33543515;
         6:  v = 32'sd16775850;
         7:  v = 32'sd8388437;
         8:  v = 32'sd4194282;
         9:  v = 32'sd2097149;
         10: v = 32'sd1048575;
         11: v = 32'sd524287;
         12: v = 32'sd262143;
         13: v = 32'sd131071;
         14: v = 32'sd65535;
         15: v = 32'sd32767;
         16: v = 32'sd16383;
         17: v = 32'sd8191;
         18: v = 32'sd4095;
         19: v = 32'sd2047;
         20: v = 32'sd1023;
         21: v = 32'sd511;
         22: v = 32'sd255;
         23: v = 32'sd127;
         24: v = 32'sd63;
         25: v = 32'sd31;
         26: v = 32'sd15;
         27: v = 32'sd7;
         28: v = 32'sd3;
         29: v = 32'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

   // one add or subtract of 2*pi into [-pi, pi)
   function automatic logic signed [WRAP_W-1:0] wrap_angle(input logic signed [WRAP_W-1:0] a);
      logic signed [WRAP_W-1:0] r;
      if (a >= ANG_PI) begin
         r = a - ANG_TWO_PI;
      end else if (a < -ANG_PI) begin
         r = a + ANG_TWO_PI;
      end else begin
         r = a;
      end
      return r;
   endfunction

   // fold into [-pi/2, pi/2], flag a sign flip of sine and cosine
   function automatic fold_type fold_angle(input logic signed [WRAP_W-1:0] a);
      fold_type                 f;
      logic signed [WRAP_W-1:0] r;
      f.neg = 1'b0;
      r     = a;
      if (a > ANG_HALF_PI) begin
         r     = a - ANG_PI;
         f.neg = 1'b1;
      end else if (a < -ANG_HALF_PI) begin
         r     = a + ANG_PI;
         f.neg = 1'b1;
      end
      f.z = r[FRAC_W-1:0];
      return f;
   endfunction

   function automatic rot_type cordic_step(input rot_type r, input int idx);
      rot_type                  o;
      logic signed [FRAC_W-1:0] xs;
      logic signed [FRAC_W-1:0] ys;
      logic signed [FRAC_W-1:0] at;
      xs = r.x >>> idx;
      ys = r.y >>> idx;
      at = atan_val(idx);
      if (!r.z[FRAC_W-1]) begin
         o.x = r.x - ys;
         o.y = r.y + xs;
         o.z = r.z - at;
      end else begin
         o.x = r.x + ys;
         o.y = r.y - xs;
         o.z = r.z + at;
      end
      return o;
   endfunction

   // Q4.60 product to Q2.30, round half up
   function automatic logic signed [FRAC_W-1:0] round_q30(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] s;
      s = p + (PROD_W'(1) <<< 29);
      return s[FRAC_W+29:30];
   endfunction

   // distance * Q2.30 to whole units, round half up, saturate
   function automatic logic signed [COORD_W-1:0] scale_sat(input logic signed [SCALE_W-1:0] q);
      logic signed [SCALE_W-1:0] s;
      logic signed [SHIFT_W-1:0] v;
      logic signed [SHIFT_W-1:0] c;
      s = q + (SCALE_W'(1) <<< 29);
      v = s[SCALE_W-1:30];
      if (v > OUT_MAX) begin
         c = OUT_MAX;
      end else if (v < OUT_MIN) begin
         c = OUT_MIN;
      end else begin
         c = v;
      end
      return c[COORD_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ rtl/spherical_to_cartesian.sv @@
// ----------------------------------------------------------------------------
// spherical_to_cartesian: polar measurement to cartesian coordinates
// x = d*sin(vz)*cos(hz), y = d*sin(vz)*sin(hz), z = d*cos(vz).
//
// Usage:
//   Request channel (req_valid/req_ready) carries one measurement: horizontal
//   and zenith angle in signed Q4.28 radians and the slope distance in tenths
//   of a millimetre. Response channel (rsp_valid/rsp_ready) carries the three
//   saturated 27-bit coordinates, one response per request, in order.
//   The pipeline stages are angle wrap, quadrant fold, the CORDIC rotations
//   (24 CORDIC stages), sign fix, two registered multiplier levels each
//   followed by a rounding stage.
//   Throughput is one transfer per cycle without receiver stalls; every stage
//   is a register with a valid bit; the two angles use parallel CORDIC lanes.
//   When the receiver stalls with a response pending, the whole pipeline
//   holds and req_ready drops in the same cycle; nothing is lost or repeated.
//   A synchronous reset clears all valid bits; no response is pending after.
// ----------------------------------------------------------------------------
`default_nettype none

module spherical_to_cartesian (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [s2c_pkg::ANG_W-1:0]     req_horizontal_angle,
   input  logic signed [s2c_pkg::ANG_W-1:0]     req_zenith_angle,
   input  logic        [s2c_pkg::DIST_W-1:0]    req_slope_distance,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [s2c_pkg::COORD_W-1:0]   rsp_coord_x,
   output logic signed [s2c_pkg::COORD_W-1:0]   rsp_coord_y,
   output logic signed [s2c_pkg::COORD_W-1:0]   rsp_coord_z
);
   import s2c_pkg::*;

   localparam int NSTG   = CORDIC_N + 7;
   localparam int S_RND1 = CORDIC_N + 4;
   localparam int S_MUL2 = CORDIC_N + 5;

   logic advance;

   logic valid_ff [NSTG];
   logic valid_in [NSTG];

   logic [DIST_W-1:0] dist_ff [S_MUL2];
   logic [DIST_W-1:0] dist_in [S_MUL2];

   // wrap stage
   logic signed [WRAP_W-1:0] wh_ff, wh_in, wv_ff, wv_in;

   // fold + CORDIC lanes
   rot_type  rot_h_ff [CORDIC_N+1];
   rot_type  rot_h_in [CORDIC_N+1];
   rot_type  rot_v_ff [CORDIC_N+1];
   rot_type  rot_v_in [CORDIC_N+1];
   logic     neg_h_ff [CORDIC_N+1];
   logic     neg_h_in [CORDIC_N+1];
   logic     neg_v_ff [CORDIC_N+1];
   logic     neg_v_in [CORDIC_N+1];
   fold_type fold_h, fold_v;

   // sign fix
   logic signed [FRAC_W-1:0] cos_h_ff, cos_h_in, sin_h_ff, sin_h_in;
   logic signed [FRAC_W-1:0] cos_v_ff, cos_v_in, sin_v_ff, sin_v_in;

   // first product level
   logic signed [PROD_W-1:0] phc_ff, phc_in, phs_ff, phs_in;
   logic signed [FRAC_W-1:0] cv1_ff, cv1_in;

   // rounding
   logic signed [FRAC_W-1:0] shc_ff, shc_in, shs_ff, shs_in, cv2_ff, cv2_in;

   // second product level
   logic signed [DIST_W:0]    dist_s;
   logic signed [SCALE_W-1:0] qx_ff, qx_in, qy_ff, qy_in, qz_ff, qz_in;

   // output register
   logic signed [COORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;

   assign advance   = !valid_ff[NSTG-1] || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      valid_in[0] = req_valid;
      for (int k = 1; k < NSTG; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
      dist_in[0] = req_slope_distance;
      for (int k = 1; k < S_MUL2; k++) begin
         dist_in[k] = dist_ff[k-1];
      end
   end

   always_comb begin
      wh_in = wrap_angle({{2{req_horizontal_angle[ANG_W-1]}}, req_horizontal_angle, 2'b00});
      wv_in = wrap_angle({{2{req_zenith_angle[ANG_W-1]}}, req_zenith_angle, 2'b00});
      fold_h = fold_angle(wh_ff);
      fold_v = fold_angle(wv_ff);
      rot_h_in[0] = '{x: INV_GAIN, y: '0, z: fold_h.z};
      rot_v_in[0] = '{x: INV_GAIN, y: '0, z: fold_v.z};
      neg_h_in[0] = fold_h.neg;
      neg_v_in[0] = fold_v.neg;
      for (int k = 0; k < CORDIC_N; k++) begin
         rot_h_in[k+1] = cordic_step(rot_h_ff[k], k);
         rot_v_in[k+1] = cordic_step(rot_v_ff[k], k);
         neg_h_in[k+1] = neg_h_ff[k];
         neg_v_in[k+1] = neg_v_ff[k];
      end
   end

   always_comb begin
      cos_h_in = neg_h_ff[CORDIC_N] ? -rot_h_ff[CORDIC_N].x : rot_h_ff[CORDIC_N].x;
      sin_h_in = neg_h_ff[CORDIC_N] ? -rot_h_ff[CORDIC_N].y : rot_h_ff[CORDIC_N].y;
      cos_v_in = neg_v_ff[CORDIC_N] ? -rot_v_ff[CORDIC_N].x : rot_v_ff[CORDIC_N].x;
      sin_v_in = neg_v_ff[CORDIC_N] ? -rot_v_ff[CORDIC_N].y : rot_v_ff[CORDIC_N].y;

      phc_in = sin_v_ff * cos_h_ff;
      phs_in = sin_v_ff * sin_h_ff;
      cv1_in = cos_v_ff;

      shc_in = round_q30(phc_ff);
      shs_in = round_q30(phs_ff);
      cv2_in = cv1_ff;

      dist_s = signed'({1'b0, dist_ff[S_RND1]});
      qx_in  = dist_s * shc_ff;
      qy_in  = dist_s * shs_ff;
      qz_in  = dist_s * cv2_ff;

      cx_in = scale_sat(qx_ff);
      cy_in = scale_sat(qy_ff);
      cz_in = scale_sat(qz_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NSTG; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         for (int k = 0; k < NSTG; k++) begin
            valid_ff[k] <= valid_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < S_MUL2; k++) begin
            dist_ff[k] <= dist_in[k];
         end
         wh_ff <= wh_in;
         wv_ff <= wv_in;
         for (int k = 0; k <= CORDIC_N; k++) begin
            rot_h_ff[k] <= rot_h_in[k];
            rot_v_ff[k] <= rot_v_in[k];
            neg_h_ff[k] <= neg_h_in[k];
            neg_v_ff[k] <= neg_v_in[k];
         end
         cos_h_ff <= cos_h_in;
         sin_h_ff <= sin_h_in;
         cos_v_ff <= cos_v_in;
         sin_v_ff <= sin_v_in;
         phc_ff   <= phc_in;
         phs_ff   <= phs_in;
         cv1_ff   <= cv1_in;
         shc_ff   <= shc_in;
         shs_ff   <= shs_in;
         cv2_ff   <= cv2_in;
         qx_ff    <= qx_in;
         qy_ff    <= qy_in;
         qz_ff    <= qz_in;
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         cz_ff    <= cz_in;
      end
   end

   assign rsp_valid   = valid_ff[NSTG-1];
   assign rsp_coord_x = cx_ff;
   assign rsp_coord_y = cy_ff;
   assign rsp_coord_z = cz_ff;

endmodule

`default_nettype wire

@@ rtl/s2c_checker.sv @@
// ----------------------------------------------------------------------------
// s2c_checker: port-level checks for spherical_to_cartesian
// Reset behavior, ready when empty, stall propagation and response hold, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module s2c_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [s2c_pkg::COORD_W-1:0]   rsp_coord_x,
   input logic signed [s2c_pkg::COORD_W-1:0]   rsp_coord_y,
   input logic signed [s2c_pkg::COORD_W-1:0]   rsp_coord_z
);

   // nothing pending right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // empty output stage never blocks the request side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with no pending response");

   // a stalled response freezes the pipeline
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken during response stall");

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_coord_x)
         && $stable(rsp_coord_y) && $stable(rsp_coord_z)))
      else $error("stalled response changed");

endmodule

bind spherical_to_cartesian s2c_checker u_s2c_checker (.*);

`default_nettype wire

@@ tb/s2c_checker.sv @@
// ----------------------------------------------------------------------------
// s2c_coord_checker: response checker for spherical_to_cartesian
// Watches both channels, predicts the cartesian coordinates of every request
// transfer with a CORDIC sine/cosine model and compares each response
// transfer, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module s2c_coord_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic signed [s2c_pkg::ANG_W-1:0]     req_horizontal_angle,
   input  logic signed [s2c_pkg::ANG_W-1:0]     req_zenith_angle,
   input  logic        [s2c_pkg::DIST_W-1:0]    req_slope_distance,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic signed [s2c_pkg::COORD_W-1:0]   rsp_coord_x,
   input  logic signed [s2c_pkg::COORD_W-1:0]   rsp_coord_y,
   input  logic signed [s2c_pkg::COORD_W-1:0]   rsp_coord_z,
   output int                                   outstanding,
   output int                                   fail_count
);

   localparam int     NUM_ROT  = (s2c_pkg::CORDIC_STAGES > 30) ? 30 : s2c_pkg::CORDIC_STAGES;
   localparam longint Q30_PI   = 64'sd3373259426;
   localparam longint Q30_HPI  = 64'sd1686629713;
   localparam longint Q30_2PI  = 64'sd6746518852;
   localparam longint CORDIC_K = 64'sd652032874;
   localparam longint SAT_HI   = 64'sd67108863;
   localparam longint SAT_LO   = -64'sd67108864;
   localparam longint HALF_LSB = 64'sd1 << 29;

   typedef struct packed {
      logic signed [s2c_pkg::COORD_W-1:0] x;
      logic signed [s2c_pkg::COORD_W-1:0] y;
      logic signed [s2c_pkg::COORD_W-1:0] z;
   } coord_type;

   longint arctan_q30 [30] = '{
      843314856, 497837829, 263043836, 133525158, 67021686,
      33543515, 16775850, 8388437, 4194282, 2097149,
      1048575, 524287, 262143, 131071, 65535,
      32767, 16383, 8191, 4095, 2047,
      1023, 511, 255, 127, 63,
      31, 15, 7, 3, 1
   };

   coord_type expected_coords [$];
   int        rsp_index;

   initial begin
      outstanding = 0;
      fail_count  = 0;
      rsp_index   = 0;
   end

   // Q4.28 angle -> sine and cosine in Q2.30
   function automatic void sin_cos_q30(input logic signed [31:0] ang,
                                       output longint sin_v, output longint cos_v);
      longint a;
      longint x;
      longint y;
      longint xs;
      longint ys;
      bit     flip;
      a    = longint'(ang) * 4;
      x    = CORDIC_K;
      y    = 0;
      flip = 1'b0;
      if (a >= Q30_PI) begin
         a = a - Q30_2PI;
      end else if (a < -Q30_PI) begin
         a = a + Q30_2PI;
      end
      if (a > Q30_HPI) begin
         a    = a - Q30_PI;
         flip = 1'b1;
      end else if (a < -Q30_HPI) begin
         a    = a + Q30_PI;
         flip = 1'b1;
      end
      for (int i = 0; i < NUM_ROT; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (a >= 0) begin
            x = x - ys;
            y = y + xs;
            a = a - arctan_q30[i];
         end else begin
            x = x + ys;
            y = y - xs;
            a = a + arctan_q30[i];
         end
      end
      cos_v = flip ? -x : x;
      sin_v = flip ? -y : y;
   endfunction

   function automatic logic signed [s2c_pkg::COORD_W-1:0] scale_to_coord(input longint meas,
                                                                         input longint f);
      longint v;
      v = (meas * f + HALF_LSB) >>> 30;
      if (v > SAT_HI) v = SAT_HI;
      if (v < SAT_LO) v = SAT_LO;
      return v[s2c_pkg::COORD_W-1:0];
   endfunction

   function automatic coord_type predict_coords(input logic signed [31:0] hz,
                                                input logic signed [31:0] vz,
                                                input logic [25:0] slope);
      coord_type c;
      longint sh, ch, sv, cv, d;
      sin_cos_q30(hz, sh, ch);
      sin_cos_q30(vz, sv, cv);
      d   = longint'(slope);
      c.x = scale_to_coord(d, (sv * ch + HALF_LSB) >>> 30);
      c.y = scale_to_coord(d, (sv * sh + HALF_LSB) >>> 30);
      c.z = scale_to_coord(d, cv);
      return c;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t s2c_checker: %s", $time, msg);
      fail_count++;
   endtask

   task automatic compare_coord(input string name, input logic signed [26:0] got,
                                input logic signed [26:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("response %0d %s: got %0d, want %0d",
                                   rsp_index, name, got, want));
      end
   endtask

   always @(posedge clock) begin : monitor
      coord_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_coords.insert(expected_coords.size(),
                                   predict_coords(req_horizontal_angle,
                                                  req_zenith_angle, req_slope_distance));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_coords.size() == 0) begin
               report_mismatch($sformatf("response %0d with no request outstanding",
                                         rsp_index));
            end else begin
               want = expected_coords.pop_front();
               compare_coord("coord_x", rsp_coord_x, want.x);
               compare_coord("coord_y", rsp_coord_y, want.y);
               compare_coord("coord_z", rsp_coord_z, want.z);
            end
            rsp_index++;
         end
      end
      outstanding <= expected_coords.size();
   end

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for spherical_to_cartesian
// Drives directed and random polar measurements through the request channel
// under several sender/receiver idle mixes, including a long receiver
// hold-off, and lets s2c_coord_checker predict and compare every response.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = s2c_pkg::CORDIC_N + 7 + 16;
   localparam int HOLD_CYCLES  = 150;
   localparam int PHASE_ITEMS  = 135;

   localparam logic signed [31:0] ANG_MAX     = 32'sh7FFFFFFF;
   localparam logic signed [31:0] ANG_MIN     = 32'sh80000000;
   localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
   localparam logic signed [31:0] PI_Q28      = 32'sd843314856;
   localparam logic signed [31:0] PI3_2_Q28   = 32'sd1264972285;
   localparam logic signed [31:0] TWO_PI_Q28  = 32'sd1686629713;
   localparam logic        [25:0] DIST_MAX    = 26'h3FFFFFF;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic signed [s2c_pkg::ANG_W-1:0]    req_horizontal_angle;
   logic signed [s2c_pkg::ANG_W-1:0]    req_zenith_angle;
   logic        [s2c_pkg::DIST_W-1:0]   req_slope_distance;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic signed [s2c_pkg::COORD_W-1:0]  rsp_coord_x;
   logic signed [s2c_pkg::COORD_W-1:0]  rsp_coord_y;
   logic signed [s2c_pkg::COORD_W-1:0]  rsp_coord_z;

   int outstanding;
   int fail_count;
   int stall_pct;
   int hold_req;
   int cycle_count;

   spherical_to_cartesian u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_horizontal_angle (req_horizontal_angle),
      .req_zenith_angle     (req_zenith_angle),
      .req_slope_distance   (req_slope_distance),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_coord_x          (rsp_coord_x),
      .rsp_coord_y          (rsp_coord_y),
      .rsp_coord_z          (rsp_coord_z)
   );

   s2c_coord_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_horizontal_angle (req_horizontal_angle),
      .req_zenith_angle     (req_zenith_angle),
      .req_slope_distance   (req_slope_distance),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_coord_x          (rsp_coord_x),
      .rsp_coord_y          (rsp_coord_y),
      .rsp_coord_z          (rsp_coord_z),
      .outstanding          (outstanding),
      .fail_count           (fail_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin : receiver
      int hold_done;
      hold_done = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req != hold_done) begin
            hold_done = hold_req;
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready = ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_measurement(input logic signed [31:0] hz, input logic signed [31:0] vz,
                                   input logic [25:0] distance, input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid            = 1'b1;
      req_horizontal_angle = hz;
      req_zenith_angle     = vz;
      req_slope_distance   = distance;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // angles cluster around wrap and fold boundaries part of the time
   function automatic logic signed [31:0] random_angle();
      int                  sel;
      logic signed [31:0]  base;
      sel = $urandom_range(9);
      if (sel < 5) return $urandom;
      if (sel < 8) begin
         case ($urandom_range(4))
            0:       base = 0;
            1:       base = HALF_PI_Q28;
            2:       base = PI_Q28;
            3:       base = PI3_2_Q28;
            default: base = TWO_PI_Q28;
         endcase
         if ($urandom_range(1)) base = -base;
         return base + $signed($urandom_range(128)) - 64;
      end
      return $signed($urandom_range(2 * PI_Q28)) - PI_Q28;
   endfunction

   function automatic logic [25:0] random_distance();
      int sel;
      sel = $urandom_range(7);
      if (sel < 4) return 26'($urandom);
      if (sel < 6) return 26'($urandom_range(255));
      return DIST_MAX - 26'($urandom_range(15));
   endfunction

   initial begin : stimulus
      int send_idle_pct;
      int p;
      int n;
      reset                = 1'b1;
      req_valid            = 1'b0;
      req_horizontal_angle = '0;
      req_zenith_angle     = '0;
      req_slope_distance   = '0;
      stall_pct            = 0;
      hold_req             = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes, wrap and fold boundaries, saturation
      send_measurement(0, 0, 0, 0);
      send_measurement(0, 0, DIST_MAX, 0);
      send_measurement(0, HALF_PI_Q28, DIST_MAX, 0);
      send_measurement(ANG_MAX, ANG_MIN, DIST_MAX, 0);
      send_measurement(ANG_MIN, ANG_MAX, DIST_MAX, 0);
      send_measurement(ANG_MAX, ANG_MAX, 1, 0);
      send_measurement(ANG_MIN, ANG_MIN, DIST_MAX, 0);
      send_measurement(HALF_PI_Q28, HALF_PI_Q28, DIST_MAX, 0);
      send_measurement(HALF_PI_Q28 + 1, HALF_PI_Q28 + 1, DIST_MAX, 0);
      send_measurement(-HALF_PI_Q28, -HALF_PI_Q28, DIST_MAX, 0);
      send_measurement(-HALF_PI_Q28 - 1, -HALF_PI_Q28 - 1, DIST_MAX, 0);
      send_measurement(PI_Q28, PI_Q28, DIST_MAX, 0);
      send_measurement(PI_Q28 + 1, PI_Q28 + 1, DIST_MAX, 0);
      send_measurement(-PI_Q28, -PI_Q28, DIST_MAX, 0);
      send_measurement(-PI_Q28 - 1, -PI_Q28 - 1, DIST_MAX, 0);
      send_measurement(TWO_PI_Q28, -TWO_PI_Q28, DIST_MAX, 0);
      send_measurement(PI3_2_Q28, -PI3_2_Q28, 26'h2AAAAAA, 0);
      send_measurement(-1, -1, 26'h1555555, 0);
      send_measurement(1, 1, 1, 0);
      send_measurement(32'sh55555555, 32'shAAAAAAAA, DIST_MAX, 0);
      send_measurement(32'shAAAAAAAA, 32'sh55555555, 26'h0000001, 0);
      wait_for_drain();

      for (p = 0; p < 4; p++) begin
         case (p)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 70; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 70; end
            default: begin send_idle_pct = 38; stall_pct = 38; end
         endcase
         if (p == 2) hold_req++;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            send_measurement(random_angle(), random_angle(), random_distance(),
                             ((n % 40) < 8) ? 0 : send_idle_pct);
         end
         wait_for_drain();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/s2c_pkg.sv
rtl/spherical_to_cartesian.sv
rtl/s2c_checker.sv
tb/s2c_checker.sv
tb/tb_top.sv
